// ===== rtl/nhpool_pkg.sv =====
`timescale 1ns / 1ps

package nhpool_pkg;

  localparam int POOL_ENTRIES_DEF = 256;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // result status codes
  localparam logic [2:0] ST_REUSED  = 3'd0;
  localparam logic [2:0] ST_STORED  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_FREED   = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  localparam logic signed [8:0] IDX_NONE = 9'h1FF;

  typedef struct packed {
    logic        family;
    logic [63:0] gw_high;
    logic [63:0] gw_low;
    logic [31:0] oif;
  } key_t;

  typedef struct packed {
    logic [15:0] count;
    key_t        key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // compare unit result
  typedef struct packed {
    logic        live;
    logic        match;
    logic        free;
    logic        last_ref;
    logic [15:0] cnt_inc;
    logic [15:0] cnt_dec;
  } cmp_t;

endpackage

// ===== rtl/refcounted_nexthop_info_pool_top.sv =====
`timescale 1ns / 1ps

// Acquire: a start step, a match scan through the entries, then, if none
// matches, a free-slot scan that starts past the hint slot, then a result step.
// Release: read, check and post; an out-of-range index skips the check.
// One item at a time; the single RAM read port sets the pace.
// Sync reset, then a clearing pass over all POOL_ENTRIES (stall held high).
// The result register lets the next item in while a result waits.
module refcounted_nexthop_info_pool_top #(
  parameter int POOL_ENTRIES = nhpool_pkg::POOL_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic               address_family,
  input  logic [63:0]        gateway_high,
  input  logic [63:0]        gateway_low,
  input  logic [31:0]        out_interface,
  input  logic signed [8:0]  entry_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [8:0]  result_index,
  output logic [2:0]         status,
  output logic [15:0]        ref_count
);

  localparam int IW = $clog2(POOL_ENTRIES);
  localparam int CW = (IW + 1 > 9) ? IW + 1 : 9;
  localparam logic [IW-1:0] LAST = IW'(POOL_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MSCAN, S_FSCAN, S_RREAD, S_RCHK, S_DONE
  } state_t;

  state_t              state;
  logic [IW-1:0]       scan;
  logic                pipe_v;
  logic [IW-1:0]       pipe_addr;
  logic [IW-1:0]       hint;
  logic [IW-1:0]       rel_idx;
  logic                rel_ok;
  nhpool_pkg::key_t    key;
  logic signed [8:0]   res_idx;
  logic [2:0]          res_status;
  logic [15:0]         res_count;

  logic                          we;
  logic [IW-1:0]                 waddr;
  logic [IW-1:0]                 raddr;
  logic [nhpool_pkg::ENTRY_W-1:0] wdata;
  logic [nhpool_pkg::ENTRY_W-1:0] rdata;
  nhpool_pkg::entry_t            rd_entry;
  nhpool_pkg::entry_t            wr_entry;
  nhpool_pkg::cmp_t              cr;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
    return (a == LAST) ? '0 : a + 1'b1;
  endfunction

  nhpool_ram #(
    .WIDTH(nhpool_pkg::ENTRY_W),
    .DEPTH(POOL_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_entry = nhpool_pkg::entry_t'(rdata);

  nhpool_cmp u_cmp (
    .entry(rd_entry),
    .key  (key),
    .res  (cr)
  );

  assign in_stall = (state != S_IDLE);
  assign raddr    = (state == S_RREAD) ? rel_idx : scan;
  assign wdata    = wr_entry;

  // RAM write side
  always_comb begin
    we       = 1'b0;
    waddr    = pipe_addr;
    wr_entry = '0;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = scan;
      end
      S_MSCAN: begin
        if (pipe_v && cr.match) begin
          we             = 1'b1;
          wr_entry.count = cr.cnt_inc;
          wr_entry.key   = rd_entry.key;
        end
      end
      S_FSCAN: begin
        if (pipe_v && cr.free) begin
          we             = 1'b1;
          wr_entry.count = 16'd1;
          wr_entry.key   = key;
        end
      end
      S_RCHK: begin
        waddr = rel_idx;
        if (cr.live) begin
          we = 1'b1;
          if (!cr.last_ref) begin
            wr_entry.count = cr.cnt_dec;
            wr_entry.key   = rd_entry.key;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan      <= '0;
      pipe_v    <= 1'b0;
      hint      <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_DONE drives out_valid itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          scan <= wrap_inc(scan);
          if (scan == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            key.family  <= address_family;
            key.gw_high <= gateway_high;
            key.gw_low  <= gateway_low;
            key.oif     <= out_interface;
            rel_idx     <= IW'(entry_index[7:0]);
            rel_ok      <= !entry_index[8] &&
                           (CW'(entry_index[7:0]) < CW'(POOL_ENTRIES));
            scan        <= '0;
            pipe_v      <= 1'b0;
            state       <= kind ? S_RREAD : S_MSCAN;
          end
        end
        S_MSCAN: begin
          // read one entry per cycle, compare it in the next cycle
          if (pipe_v && cr.match) begin
            res_idx    <= 9'(pipe_addr);
            res_status <= nhpool_pkg::ST_REUSED;
            res_count  <= cr.cnt_inc;
            pipe_v     <= 1'b0;
            state      <= S_DONE;
          end else if (pipe_v && pipe_addr == LAST) begin
            scan   <= wrap_inc(hint);
            pipe_v <= 1'b0;
            state  <= S_FSCAN;
          end else begin
            pipe_v    <= 1'b1;
            pipe_addr <= scan;
            scan      <= wrap_inc(scan);
          end
        end
        S_FSCAN: begin
          // hint slot itself is never a candidate
          if (pipe_v && cr.free) begin
            res_idx    <= 9'(pipe_addr);
            res_status <= nhpool_pkg::ST_STORED;
            res_count  <= 16'd1;
            hint       <= wrap_inc(pipe_addr);
            pipe_v     <= 1'b0;
            state      <= S_DONE;
          end else if (pipe_v && wrap_inc(pipe_addr) == hint) begin
            res_idx    <= nhpool_pkg::IDX_NONE;
            res_status <= nhpool_pkg::ST_FULL;
            res_count  <= 16'd0;
            pipe_v     <= 1'b0;
            state      <= S_DONE;
          end else begin
            pipe_v    <= 1'b1;
            pipe_addr <= scan;
            scan      <= wrap_inc(scan);
          end
        end
        S_RREAD: begin
          if (rel_ok) begin
            state <= S_RCHK;
          end else begin
            res_idx    <= nhpool_pkg::IDX_NONE;
            res_status <= nhpool_pkg::ST_IGNORED;
            res_count  <= 16'd0;
            state      <= S_DONE;
          end
        end
        S_RCHK: begin
          if (!cr.live) begin
            res_idx    <= nhpool_pkg::IDX_NONE;
            res_status <= nhpool_pkg::ST_IGNORED;
            res_count  <= 16'd0;
          end else if (cr.last_ref) begin
            res_idx    <= 9'(rel_idx);
            res_status <= nhpool_pkg::ST_FREED;
            res_count  <= 16'd0;
          end else begin
            res_idx    <= 9'(rel_idx);
            res_status <= nhpool_pkg::ST_DROPPED;
            res_count  <= cr.cnt_dec;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            result_index <= res_idx;
            status       <= res_status;
            ref_count    <= res_count;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/nhpool_ram.sv =====
`timescale 1ns / 1ps

module nhpool_ram #(
  parameter int WIDTH = nhpool_pkg::ENTRY_W,
  parameter int DEPTH = nhpool_pkg::POOL_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nhpool_cmp.sv =====
`timescale 1ns / 1ps

// Shared entry compare unit: checks one stored entry against the item key
// and prepares the bumped and dropped counts.
module nhpool_cmp (
  input  nhpool_pkg::entry_t entry,
  input  nhpool_pkg::key_t   key,
  output nhpool_pkg::cmp_t   res
);

  always_comb begin
    res.live     = (entry.count != 16'd0);
    res.free     = (entry.count == 16'd0);
    res.match    = res.live && (entry.key == key);
    res.last_ref = (entry.count == 16'd1);
    res.cnt_inc  = (entry.count == nhpool_pkg::COUNT_MAX) ? entry.count
                                                          : entry.count + 16'd1;
    res.cnt_dec  = entry.count - 16'd1;
  end

endmodule

// ===== rtl/nhpool_chk.sv =====
`timescale 1ns / 1ps

module nhpool_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [8:0] result_index,
  input logic [2:0]        status,
  input logic [15:0]       ref_count
);

  // held result transfer must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_index) &&
      $stable(status) && $stable(ref_count))
    else $error("result changed while stalled");

  // a pool busy with an item takes no other
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in flight");

  a_none_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == nhpool_pkg::ST_FULL || status == nhpool_pkg::ST_IGNORED)
      |-> result_index == nhpool_pkg::IDX_NONE && ref_count == 16'd0)
    else $error("full or ignored result carries an index or count");

  a_stored_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == nhpool_pkg::ST_STORED
      |-> ref_count == 16'd1 && result_index != nhpool_pkg::IDX_NONE)
    else $error("new entry without count one");

  a_count_vs_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == nhpool_pkg::ST_REUSED || status == nhpool_pkg::ST_DROPPED)
      |-> ref_count != 16'd0)
    else $error("live entry reported with zero count");

endmodule

bind refcounted_nexthop_info_pool_top nhpool_chk u_nhpool_chk (.*);

// ===== test/refcounted_nexthop_info_pool_top_tb.sv =====
`timescale 1ns / 1ps

module refcounted_nexthop_info_pool_top_tb;
  import nhpool_pkg::*;

  localparam int POOL_N = POOL_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1170;
  localparam int QUIET_FROM = 1050;
  localparam int HOLD_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct {
    logic              kind;
    key_t              key;
    logic signed [8:0] idx;
  } nh_item_t;

  typedef struct {
    logic signed [8:0] index;
    logic [2:0]        code;
    logic [15:0]       count;
  } pool_outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              kind = 1'b0;
  logic              address_family = 1'b0;
  logic [63:0]       gateway_high = '0;
  logic [63:0]       gateway_low = '0;
  logic [31:0]       out_interface = '0;
  logic signed [8:0] entry_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [8:0] result_index;
  logic [2:0]        status;
  logic [15:0]       ref_count;

  refcounted_nexthop_info_pool_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .address_family(address_family),
    .gateway_high(gateway_high), .gateway_low(gateway_low),
    .out_interface(out_interface), .entry_index(entry_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_index(result_index), .status(status), .ref_count(ref_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the pool
  logic [15:0]   shadow_count [POOL_N];
  key_t          shadow_key [POOL_N];
  int            shadow_hint;

  nh_item_t      pending_items[$];
  pool_outcome_t expected_outcomes[$];
  int            mismatches = 0;
  int            checked = 0;
  int            outcome_seen [8];
  int            cycle_count = 0;
  logic          idle_on = 1'b1;
  logic          hold_req = 1'b0;
  logic          hold_done = 1'b0;
  int            hold_left = 0;
  int            rx_burst = 0;
  int            tx_gap = 0;
  nh_item_t      next_item;
  key_t          offered_key;

  initial begin
    for (int i = 0; i < POOL_N; i++) begin
      shadow_count[i] = '0;
      shadow_key[i] = '0;
    end
    shadow_hint = 0;
    for (int i = 0; i < 8; i++) outcome_seen[i] = 0;
  end

  // one acquire or release applied to the shadow pool
  task automatic pool_step(input logic k, input key_t key, input logic signed [8:0] idx);
    pool_outcome_t o;
    bit            hit;
    int            i;
    int            slot;
    o.index = IDX_NONE;
    o.code = ST_FULL;
    o.count = '0;
    hit = 1'b0;
    if (k == KIND_ACQUIRE) begin
      for (i = 0; i < POOL_N; i++) begin
        if (!hit && shadow_count[i] != 0 && shadow_key[i] == key) begin
          if (shadow_count[i] != COUNT_MAX) shadow_count[i] = shadow_count[i] + 16'd1;
          o.index = 9'(i);
          o.code = ST_REUSED;
          o.count = shadow_count[i];
          hit = 1'b1;
        end
      end
      // free scan skips the hint slot itself
      i = (shadow_hint + 1) % POOL_N;
      while (!hit && i != shadow_hint) begin
        if (shadow_count[i] == 0) begin
          shadow_key[i] = key;
          shadow_count[i] = 16'd1;
          shadow_hint = (i + 1) % POOL_N;
          o.index = 9'(i);
          o.code = ST_STORED;
          o.count = 16'd1;
          hit = 1'b1;
        end else begin
          i = (i + 1) % POOL_N;
        end
      end
    end else begin
      slot = int'($unsigned(idx));
      o.code = ST_IGNORED;
      if (!idx[8] && slot < POOL_N && shadow_count[slot] != 0) begin
        shadow_count[slot] = shadow_count[slot] - 16'd1;
        o.index = idx;
        o.count = shadow_count[slot];
        if (shadow_count[slot] == 0) begin
          shadow_key[slot] = '0;
          o.code = ST_FREED;
        end else begin
          o.code = ST_DROPPED;
        end
      end
    end
    expected_outcomes.push_back(o);
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        offered_key = {address_family, gateway_high, gateway_low, out_interface};
        pool_step(kind, offered_key, entry_index);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          if (idle_on && $urandom_range(5) == 0) begin
            tx_gap <= $urandom_range(4);
            in_valid <= 1'b0;
          end else begin
            next_item = pending_items.pop_front();
            kind <= next_item.kind;
            address_family <= next_item.key.family;
            gateway_high <= next_item.key.gw_high;
            gateway_low <= next_item.key.gw_low;
            out_interface <= next_item.key.oif;
            entry_index <= next_item.idx;
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: short bursts, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_burst <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (rx_burst != 0) begin
      rx_burst <= rx_burst - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(4) == 0) begin
      rx_burst <= $urandom_range(4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    pool_outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        note_mismatch($sformatf("unexpected result index %0d status %0d count %0d",
                                result_index, status, ref_count));
      end else begin
        want = expected_outcomes.pop_front();
        if (result_index !== want.index)
          note_mismatch($sformatf("result_index %0d, expected %0d", result_index, want.index));
        if (status !== want.code)
          note_mismatch($sformatf("status %0d, expected %0d", status, want.code));
        if (ref_count !== want.count)
          note_mismatch($sformatf("ref_count %0d, expected %0d", ref_count, want.count));
        outcome_seen[want.code]++;
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_outcomes.size());
      $display("refcounted_nexthop_info_pool_top regression: fail");
      $finish;
    end
  end

  function automatic key_t fresh_key();
    key_t k;
    k.family = 1'($urandom_range(1));
    k.gw_high = {$urandom, $urandom};
    k.gw_low = {$urandom, $urandom};
    k.oif = $urandom;
    if ($urandom_range(15) == 0) k = '1;
    if ($urandom_range(15) == 0) k.gw_high = '0;
    return k;
  endfunction

  // differs from k in a single bit
  function automatic key_t near_miss(key_t k);
    int f;
    f = $urandom_range(3);
    case (f)
      0: k.family = ~k.family;
      1: k.gw_high = k.gw_high ^ (64'd1 << $urandom_range(63));
      2: k.gw_low = k.gw_low ^ (64'd1 << $urandom_range(63));
      default: k.oif = k.oif ^ (32'd1 << $urandom_range(31));
    endcase
    return k;
  endfunction

  function automatic nh_item_t acquire_of(key_t k);
    nh_item_t it;
    it.kind = KIND_ACQUIRE;
    it.key = k;
    it.idx = 9'($urandom_range(511));
    return it;
  endfunction

  function automatic nh_item_t release_of(logic signed [8:0] idx);
    nh_item_t it;
    it.kind = KIND_RELEASE;
    it.key = fresh_key();
    it.idx = idx;
    return it;
  endfunction

  function automatic int pick_live();
    int live[$];
    for (int i = 0; i < POOL_N; i++)
      if (shadow_count[i] != 0) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(live.size() - 1)];
  endfunction

  task automatic offer(input nh_item_t it);
    while (pending_items.size() >= 2) @(negedge clk);
    pending_items.push_back(it);
  endtask

  initial begin
    key_t zero_key;
    key_t ones_key;
    key_t k;
    key_t hot [6];
    int   made;
    int   pick;
    int   drain_left;
    int   r;
    zero_key = '0;
    ones_key = '1;
    made = 0;
    drain_left = 0;
    hot[0] = fresh_key();
    hot[1] = hot[0];
    hot[1].family = ~hot[0].family;
    hot[2] = fresh_key();
    hot[3] = hot[2];
    hot[3].oif = hot[2].oif ^ 32'd1;
    hot[4] = ones_key;
    hot[5] = fresh_key();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: first store lands past the hint slot, reuse, single-field differences
    offer(acquire_of(zero_key));
    offer(acquire_of(zero_key));
    k = ones_key;
    k.family = 1'b1;
    offer(acquire_of(k));
    k = zero_key;
    k.family = 1'b1;
    offer(acquire_of(k));
    k = zero_key;
    k.oif[31] = 1'b1;
    offer(acquire_of(k));
    k = zero_key;
    k.gw_low[0] = 1'b1;
    offer(acquire_of(k));
    k = zero_key;
    k.gw_high[63] = 1'b1;
    offer(acquire_of(k));
    // count down to free, then releases that must be ignored
    offer(release_of(9'sd1));
    offer(release_of(9'sd1));
    offer(release_of(9'sd1));
    offer(release_of(-9'sd1));
    offer(release_of(9'sh100));
    offer(release_of(9'sd255));
    offer(release_of(9'sd0));
    // freed key comes back in a new slot
    offer(acquire_of(zero_key));
    offer(acquire_of(ones_key));
    offer(release_of(9'sd2));
    offer(release_of(9'sd2));
    offer(release_of(9'sd3));
    offer(acquire_of(fresh_key()));

    while (made < RANDOM_ITEMS) begin
      @(negedge clk);
      if (made >= QUIET_FROM) idle_on <= 1'b0;
      else if (made % 100 == 0) idle_on <= ($urandom_range(3) != 0);
      if (made == 150) hold_req <= 1'b1;
      if (made == 300 || made == 800) begin
        // fill the pool past capacity, then drain it
        for (int n = 0; n < POOL_N + 6; n++) begin
          offer(acquire_of(fresh_key()));
          made++;
        end
        drain_left = 220;
      end
      r = $urandom_range(99);
      if (drain_left > 0) begin
        drain_left--;
        r = (r < 85) ? 70 : r % 60;
      end
      if (r < 30) begin
        offer(acquire_of(hot[$urandom_range(5)]));
        made++;
      end else if (r < 45) begin
        offer(acquire_of(near_miss(hot[$urandom_range(5)])));
        made++;
      end else if (r < 60) begin
        offer(acquire_of(fresh_key()));
        made++;
      end else if (r < 90) begin
        pick = pick_live();
        if (pick < 0) offer(acquire_of(hot[$urandom_range(5)]));
        else offer(release_of(9'(pick)));
        made++;
      end else begin
        offer(release_of(9'($urandom_range(511))));
      end
    end

    while (pending_items.size() != 0 || in_valid || expected_outcomes.size() != 0)
      @(negedge clk);
    repeat (2 * POOL_N + 8) @(posedge clk);

    $display("checked %0d transfers in %0d cycles: reused %0d, stored %0d, pool full %0d,",
             checked, cycle_count, outcome_seen[ST_REUSED], outcome_seen[ST_STORED],
             outcome_seen[ST_FULL]);
    $display("  count dropped %0d, freed %0d, ignored %0d; %0d mismatches",
             outcome_seen[ST_DROPPED], outcome_seen[ST_FREED], outcome_seen[ST_IGNORED],
             mismatches);
    if (mismatches == 0) begin
      $display("refcounted_nexthop_info_pool_top regression: pass");
    end else begin
      $display("refcounted_nexthop_info_pool_top regression: fail");
    end
    $finish;
  end

endmodule
